// ===== design/rpqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpqs_pkg
// Shared types and constants of the range pair qualify statistics block.
// ----------------------------------------------------------------------------
package rpqs_pkg;

  // field widths of the channels
  localparam int STRENGTH_W = 16;
  localparam int DIST_W     = 16;
  localparam int INDEX_W    = 3;
  localparam int MEAN_W     = 26;
  localparam int DEV_W      = 24;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 3;
  localparam int THR_W      = 24;
  localparam int OFF_W      = 24;
  localparam int VAR_W      = 64;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_STRENGTH_MIN  = 2'd0;
  localparam logic [1:0] REG_TURN_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_OFFSET_X      = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y      = 2'd3;

  localparam logic [STRENGTH_W-1:0] STRENGTH_MIN_RST  = 16'd60;
  localparam logic [THR_W-1:0]      TURN_THRESHOLD_RST = 24'd1536;

  localparam logic OP_START = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic KIND_SENSOR = 1'b0;
  localparam logic KIND_AXIS   = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CW   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CCW  = 2'd2;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SWEEP = 10'b00_0000_0010,
    ST_SQR   = 10'b00_0000_0100,
    ST_SUBT  = 10'b00_0000_1000,
    ST_DIVM  = 10'b00_0001_0000,
    ST_DIVV  = 10'b00_0010_0000,
    ST_SQRT  = 10'b00_0100_0000,
    ST_FIN   = 10'b00_1000_0000,
    ST_EMITS = 10'b01_0000_0000,
    ST_SQRT2 = 10'b10_0000_0000
  } state_t;

endpackage

// ===== design/rpqs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpqs_in_if / rpqs_out_if
// Valid/ready channels for reading transactions and result transactions.
// ----------------------------------------------------------------------------
interface rpqs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic                               read_ok;
  logic                               reading_valid;
  logic [rpqs_pkg::STRENGTH_W-1:0]    strength;
  logic [rpqs_pkg::DIST_W-1:0]        distance_cm;

  modport source (output valid, op, read_ok, reading_valid, strength, distance_cm,
                  input ready);
  modport sink (input valid, op, read_ok, reading_valid, strength, distance_cm,
                output ready);
endinterface

interface rpqs_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [rpqs_pkg::INDEX_W-1:0]       index;
  logic                               status;
  logic signed [rpqs_pkg::MEAN_W-1:0] mean_q8;
  logic [rpqs_pkg::DEV_W-1:0]         deviation_q8;
  logic                               deviation_valid;
  logic [rpqs_pkg::CMD_W-1:0]         command;
  logic [rpqs_pkg::COUNT_W-1:0]       accepted_count;
  logic                               last;

  modport source (output valid, kind, index, status, mean_q8, deviation_q8,
                  deviation_valid, command, accepted_count, last, input ready);
  modport sink (input valid, kind, index, status, mean_q8, deviation_q8,
                deviation_valid, command, accepted_count, last, output ready);
endinterface

// ===== design/range_pair_qualify_stats_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_pair_qualify_stats_core
// Qualified range readings per sensor; sensor and axis pair statistics.
// ----------------------------------------------------------------------------
// A start transaction (op 0) opens a run at sensor 1 and gives no result.
// Each reading transaction (op 1) is one attempt for the current sensor. A
// closing attempt starts a sequencer around one shared 64-bit
// compare/subtract unit: a sweep over the stored samples, a squaring step and
// a subtraction step, a restoring divide for the mean, a restoring divide for
// the variance and a 32-step integer square root; a pair end adds another
// 32-step root for the pooled deviation. An empty series skips both divides
// and the root, a one-sample series skips the variance divide and the root,
// and a pair end with such a series in the pair skips the pooled root.
// The input channel is ready only while no series is being closed. Results
// sit in an output register; a stalled receiver holds the sequencer until
// each result is taken. Reset restores the register defaults and opens a
// run at sensor 1. Configuration is written through the APB-style port.
// ----------------------------------------------------------------------------
module range_pair_qualify_stats_core #(
  parameter int MAX_ACCEPTED = 5,
  parameter int MAX_ATTEMPTS = 10,
  parameter int SENSOR_COUNT = 4,
  parameter int DIST_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rpqs_in_if.sink                         in_ch,
  rpqs_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpqs_pkg::CFG_AW-1:0]     paddr,
  input  logic [rpqs_pkg::CFG_DW-1:0]     pwdata,
  output logic [rpqs_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int N_W     = $clog2(MAX_ACCEPTED + 1);
  localparam int A_W     = $clog2(MAX_ATTEMPTS + 1);
  localparam int IDX_W   = (MAX_ACCEPTED > 1) ? $clog2(MAX_ACCEPTED) : 1;
  localparam int TAKE_W  = (DIST_BITS < rpqs_pkg::DIST_W) ? DIST_BITS : rpqs_pkg::DIST_W;
  localparam int SUM_W   = DIST_BITS + N_W;
  localparam int SQ_W    = 2 * DIST_BITS + N_W;
  localparam int S_W     = 2 * SUM_W;
  localparam int D_W     = 2 * N_W;
  localparam int DVD_W   = S_W + 16;
  localparam int QW      = (DVD_W > rpqs_pkg::VAR_W) ? DVD_W : rpqs_pkg::VAR_W;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int MEAN_SH = DVD_W - SUM_W - 8;
  localparam int VW      = rpqs_pkg::VAR_W;

  rpqs_pkg::state_t state_r;

  // configuration
  logic [rpqs_pkg::STRENGTH_W-1:0] smin_r;
  logic [rpqs_pkg::THR_W-1:0]      thr_r;
  logic [rpqs_pkg::OFF_W-1:0]      offx_r, offy_r;

  // series and pair state
  logic [DIST_BITS-1:0] store_r [MAX_ACCEPTED];
  logic [N_W-1:0]       acc_r;
  logic [A_W-1:0]       att_r;
  logic [1:0]           sensor_r;
  logic [23:0]          fmean_r;
  logic [VW-1:0]        fvar_r;
  logic                 ferr_r, fvinv_r;

  // datapath
  logic [N_W-1:0]   idx_r;
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sumsq_r;
  logic [S_W-1:0]   sq_r, s_r;
  logic [DVD_W-1:0] dvd_r;
  logic [D_W-1:0]   rem_r, div_r;
  logic [QW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    v_r, root_r, bit_r, var_r;
  logic [23:0]      mean_r, sdev_r;

  // output register
  logic                               ov_r, okind_r, ostat_r, odv_r, olast_r;
  logic [rpqs_pkg::INDEX_W-1:0]       oidx_r;
  logic signed [rpqs_pkg::MEAN_W-1:0] omean_r;
  logic [rpqs_pkg::DEV_W-1:0]         odev_r;
  logic [rpqs_pkg::CMD_W-1:0]         ocmd_r;
  logic [rpqs_pkg::COUNT_W-1:0]       ocnt_r;

  // ---------------- combinational helpers ----------------
  logic                 in_fire, out_fire, cfg_wr;
  logic [DIST_BITS-1:0] dist_in, x;
  logic                 qualify, closing;
  logic [N_W-1:0]       acc_nxt;
  logic [A_W-1:0]       att_nxt;
  logic [2*DIST_BITS-1:0] xsq;
  logic [S_W-1:0]       sum_sq, nsq;
  logic [D_W-1:0]       dd;
  logic [D_W:0]         rem2;
  logic [VW-1:0]        cmp_a, cmp_b;
  logic [VW:0]          diff;
  logic                 ge, div_mode;
  logic [QW-1:0]        quo_step;
  logic [VW-1:0]        root_step;
  logic                 err, vinv, pair_end;
  logic [2:0]           sensor_inc;
  logic [1:0]           sensor_nxt;
  logic [24:0]          msum;
  logic signed [25:0]   pair_mean, mdiff, thr_s;
  logic [rpqs_pkg::CMD_W-1:0] axis_cmd;
  logic [VW-1:0]        pooled;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_ch.ready = (state_r == rpqs_pkg::ST_IDLE);

  assign dist_in = DIST_BITS'(in_ch.distance_cm[TAKE_W-1:0]);
  assign qualify = in_ch.read_ok & in_ch.reading_valid & (in_ch.strength > smin_r)
                   & (acc_r < N_W'(MAX_ACCEPTED));
  assign acc_nxt = acc_r + N_W'(qualify);
  assign att_nxt = att_r + A_W'(1);
  assign closing = !((acc_nxt < N_W'(MAX_ACCEPTED)) && (att_nxt < A_W'(MAX_ATTEMPTS)));

  assign x      = store_r[idx_r[IDX_W-1:0]];
  assign xsq    = x * x;
  assign sum_sq = sum_r * sum_r;
  assign nsq    = S_W'(acc_r) * S_W'(sumsq_r);
  assign dd     = D_W'(acc_r) * D_W'(acc_r - N_W'(1));

  // shared compare/subtract: divide step or square-root step
  assign div_mode = (state_r == rpqs_pkg::ST_DIVM) || (state_r == rpqs_pkg::ST_DIVV);
  assign rem2     = {rem_r, dvd_r[DVD_W-1]};
  always_comb begin
    if (div_mode) begin
      cmp_a = VW'(rem2);
      cmp_b = VW'(div_r);
    end else begin
      cmp_a = v_r;
      cmp_b = root_r | bit_r;
    end
  end
  assign diff      = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign ge        = ~diff[VW];
  assign quo_step  = {quo_r[QW-2:0], ge};
  assign root_step = ge ? ((root_r >> 1) | bit_r) : (root_r >> 1);

  assign err      = (acc_r == '0);
  assign vinv     = (acc_r < N_W'(2));
  assign pair_end = sensor_r[0];
  assign sensor_inc = {1'b0, sensor_r} + 3'd1;
  assign sensor_nxt = (sensor_inc >= 3'(SENSOR_COUNT)) ? 2'd0 : sensor_inc[1:0];

  assign msum      = {1'b0, fmean_r} + {1'b0, mean_r};
  assign pair_mean = 26'(msum[24:1])
                   + 26'(signed'(sensor_r[1] ? offy_r : offx_r));
  assign mdiff     = 26'({1'b0, fmean_r}) - 26'({1'b0, mean_r});
  assign thr_s     = 26'({1'b0, thr_r});
  always_comb begin
    if (mdiff > thr_s)       axis_cmd = rpqs_pkg::CMD_CW;
    else if (mdiff < -thr_s) axis_cmd = rpqs_pkg::CMD_CCW;
    else                     axis_cmd = rpqs_pkg::CMD_NONE;
  end
  assign pooled = (fvar_r >> 1) + (var_r >> 1) + VW'(fvar_r[0] & var_r[0]);

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      rpqs_pkg::REG_STRENGTH_MIN:   prdata = 32'(smin_r);
      rpqs_pkg::REG_TURN_THRESHOLD: prdata = 32'(thr_r);
      rpqs_pkg::REG_OFFSET_X:       prdata = 32'(offx_r);
      rpqs_pkg::REG_OFFSET_Y:       prdata = 32'(offy_r);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smin_r <= rpqs_pkg::STRENGTH_MIN_RST;
      thr_r  <= rpqs_pkg::TURN_THRESHOLD_RST;
      offx_r <= '0;
      offy_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rpqs_pkg::REG_STRENGTH_MIN:   smin_r <= pwdata[rpqs_pkg::STRENGTH_W-1:0];
        rpqs_pkg::REG_TURN_THRESHOLD: thr_r  <= pwdata[rpqs_pkg::THR_W-1:0];
        rpqs_pkg::REG_OFFSET_X:       offx_r <= pwdata[rpqs_pkg::OFF_W-1:0];
        rpqs_pkg::REG_OFFSET_Y:       offy_r <= pwdata[rpqs_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // sample store: no reset, only entries of the current series are read
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == rpqs_pkg::OP_READ && qualify) begin
      store_r[acc_r[IDX_W-1:0]] <= dist_in;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rpqs_pkg::ST_IDLE;
      acc_r    <= '0;
      att_r    <= '0;
      sensor_r <= '0;
      fmean_r  <= '0;
      fvar_r   <= '0;
      ferr_r   <= 1'b0;
      fvinv_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      unique case (state_r)
        rpqs_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.op == rpqs_pkg::OP_START) begin
              acc_r    <= '0;
              att_r    <= '0;
              sensor_r <= '0;
              fmean_r  <= '0;
              fvar_r   <= '0;
              ferr_r   <= 1'b0;
              fvinv_r  <= 1'b0;
            end else begin
              acc_r <= acc_nxt;
              att_r <= att_nxt;
              if (closing) begin
                idx_r   <= '0;
                sum_r   <= '0;
                sumsq_r <= '0;
                state_r <= rpqs_pkg::ST_SWEEP;
              end
            end
          end
        end
        rpqs_pkg::ST_SWEEP: begin
          if (idx_r == acc_r) begin
            state_r <= rpqs_pkg::ST_SQR;
          end else begin
            sum_r   <= sum_r + SUM_W'(x);
            sumsq_r <= sumsq_r + SQ_W'(xsq);
            idx_r   <= idx_r + N_W'(1);
          end
        end
        rpqs_pkg::ST_SQR: begin
          sq_r    <= sum_sq;
          state_r <= rpqs_pkg::ST_SUBT;
        end
        rpqs_pkg::ST_SUBT: begin
          s_r <= nsq - sq_r;
          if (err) begin
            mean_r  <= '0;
            var_r   <= '0;
            sdev_r  <= '0;
            state_r <= rpqs_pkg::ST_FIN;
          end else begin
            // left-align sum*256 so the divide shifts out its top bit first
            dvd_r   <= DVD_W'({sum_r, 8'd0}) << MEAN_SH;
            cnt_r   <= CNT_W'(SUM_W + 8);
            rem_r   <= '0;
            quo_r   <= '0;
            div_r   <= D_W'(acc_r);
            state_r <= rpqs_pkg::ST_DIVM;
          end
        end
        rpqs_pkg::ST_DIVM, rpqs_pkg::ST_DIVV: begin
          rem_r <= ge ? diff[D_W-1:0] : rem2[D_W-1:0];
          quo_r <= quo_step;
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            if (state_r == rpqs_pkg::ST_DIVM) begin
              mean_r <= (|quo_step[QW-1:24]) ? 24'hFF_FFFF : quo_step[23:0];
              if (vinv) begin
                var_r   <= '0;
                sdev_r  <= '0;
                state_r <= rpqs_pkg::ST_FIN;
              end else begin
                dvd_r   <= {s_r, 16'd0};
                cnt_r   <= CNT_W'(DVD_W);
                rem_r   <= '0;
                quo_r   <= '0;
                div_r   <= dd;
                state_r <= rpqs_pkg::ST_DIVV;
              end
            end else begin
              var_r   <= quo_step[VW-1:0];
              v_r     <= quo_step[VW-1:0];
              root_r  <= '0;
              bit_r   <= VW'(1) << (VW - 2);
              state_r <= rpqs_pkg::ST_SQRT;
            end
          end
        end
        rpqs_pkg::ST_SQRT, rpqs_pkg::ST_SQRT2: begin
          if (ge) v_r <= diff[VW-1:0];
          root_r <= root_step;
          bit_r  <= bit_r >> 2;
          if (bit_r[0]) begin
            if (state_r == rpqs_pkg::ST_SQRT) begin
              sdev_r  <= (|root_step[VW-1:24]) ? 24'hFF_FFFF : root_step[23:0];
              state_r <= rpqs_pkg::ST_FIN;
            end else begin
              ov_r    <= 1'b1;
              okind_r <= rpqs_pkg::KIND_AXIS;
              oidx_r  <= 3'(sensor_r[1]);
              ostat_r <= rpqs_pkg::STATUS_OK;
              omean_r <= pair_mean;
              odev_r  <= (|root_step[VW-1:24]) ? 24'hFF_FFFF : root_step[23:0];
              odv_r   <= 1'b1;
              ocmd_r  <= axis_cmd;
              ocnt_r  <= '0;
              olast_r <= 1'b1;
              state_r <= rpqs_pkg::ST_EMITS;
            end
          end
        end
        rpqs_pkg::ST_FIN: begin
          ov_r    <= 1'b1;
          okind_r <= rpqs_pkg::KIND_SENSOR;
          oidx_r  <= 3'(sensor_r) + 3'd1;
          ostat_r <= err ? rpqs_pkg::STATUS_ERR : rpqs_pkg::STATUS_OK;
          omean_r <= 26'(mean_r);
          odev_r  <= sdev_r;
          odv_r   <= ~vinv;
          ocmd_r  <= rpqs_pkg::CMD_NONE;
          ocnt_r  <= (acc_r > N_W'(7)) ? 3'd7 : 3'(acc_r);
          olast_r <= ~pair_end;
          state_r <= rpqs_pkg::ST_EMITS;
        end
        rpqs_pkg::ST_EMITS: begin
          if (out_fire) begin
            ov_r <= 1'b0;
            if (okind_r == rpqs_pkg::KIND_SENSOR && pair_end) begin
              if (ferr_r || err || fvinv_r || vinv) begin
                // axis result without a pooled root
                ov_r    <= 1'b1;
                okind_r <= rpqs_pkg::KIND_AXIS;
                oidx_r  <= 3'(sensor_r[1]);
                ostat_r <= (ferr_r || err) ? rpqs_pkg::STATUS_ERR : rpqs_pkg::STATUS_OK;
                omean_r <= (ferr_r || err) ? '0 : pair_mean;
                odev_r  <= '0;
                odv_r   <= 1'b0;
                ocmd_r  <= (ferr_r || err) ? rpqs_pkg::CMD_NONE : axis_cmd;
                ocnt_r  <= '0;
                olast_r <= 1'b1;
              end else begin
                v_r     <= pooled;
                root_r  <= '0;
                bit_r   <= VW'(1) << (VW - 2);
                state_r <= rpqs_pkg::ST_SQRT2;
              end
            end else begin
              // series done: hold stats after a pair's first sensor, advance sensor
              if (!pair_end) begin
                if (sensor_nxt == 2'd0) begin
                  fmean_r <= '0;
                  fvar_r  <= '0;
                  ferr_r  <= 1'b0;
                  fvinv_r <= 1'b0;
                end else begin
                  fmean_r <= mean_r;
                  fvar_r  <= var_r;
                  ferr_r  <= err;
                  fvinv_r <= vinv;
                end
              end
              acc_r    <= '0;
              att_r    <= '0;
              sensor_r <= sensor_nxt;
              state_r  <= rpqs_pkg::ST_IDLE;
            end
          end
        end
        default: state_r <= rpqs_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.kind            = okind_r;
  assign out_ch.index           = oidx_r;
  assign out_ch.status          = ostat_r;
  assign out_ch.mean_q8         = omean_r;
  assign out_ch.deviation_q8    = odev_r;
  assign out_ch.deviation_valid = odv_r;
  assign out_ch.command         = ocmd_r;
  assign out_ch.accepted_count  = ocnt_r;
  assign out_ch.last            = olast_r;

  // ---------------- assertions ----------------
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == rpqs_pkg::ST_EMITS))
    else $error("result valid outside emit state");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= N_W'(MAX_ACCEPTED))
    else $error("accepted count beyond limit");

  a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpqs_pkg::ST_IDLE) |-> (att_r < A_W'(MAX_ATTEMPTS)))
    else $error("closed series left open in idle");

  a_axis_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == rpqs_pkg::KIND_AXIS) |-> (olast_r && ocnt_r == '0))
    else $error("axis result not marked last");

  a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.op == rpqs_pkg::OP_READ && closing)
      |=> (state_r == rpqs_pkg::ST_SWEEP))
    else $error("closing reading did not start the sequencer");

endmodule
